>>> sv/cae_pkg.sv
// shared types and constants for the 8-bit cpu execute core
// no dependencies; used by the interfaces, cae_alu and the top level
`default_nettype none

package cae_pkg;

	localparam int OP_W   = 6;
	localparam int DATA_W = 8;
	localparam int FLAG_W = 6;

	// flag positions inside the internal flag word
	localparam int FLG_C = 0;
	localparam int FLG_Z = 1;
	localparam int FLG_I = 2;
	localparam int FLG_D = 3;
	localparam int FLG_V = 4;
	localparam int FLG_N = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ADC   = 6'd0,
		OP_SBC   = 6'd1,
		OP_CMP   = 6'd2,
		OP_CPX   = 6'd3,
		OP_CPY   = 6'd4,
		OP_DEC   = 6'd5,
		OP_INC   = 6'd6,
		OP_LSR   = 6'd7,
		OP_ASL   = 6'd8,
		OP_ROL   = 6'd9,
		OP_ROR   = 6'd10,
		OP_BIT   = 6'd11,
		OP_AND   = 6'd12,
		OP_EOR   = 6'd13,
		OP_ORA   = 6'd14,
		OP_LDA   = 6'd15,
		OP_LDX   = 6'd16,
		OP_LDY   = 6'd17,
		OP_STA   = 6'd18,
		OP_STX   = 6'd19,
		OP_STY   = 6'd20,
		OP_NOP   = 6'd21,
		OP_LAX   = 6'd22,
		OP_SAX   = 6'd23,
		OP_DCP   = 6'd24,
		OP_ISB   = 6'd25,
		OP_SLO   = 6'd26,
		OP_RLA   = 6'd27,
		OP_SRE   = 6'd28,
		OP_RRA   = 6'd29,
		OP_INX   = 6'd30,
		OP_INY   = 6'd31,
		OP_DEX   = 6'd32,
		OP_DEY   = 6'd33,
		OP_TAX   = 6'd34,
		OP_TAY   = 6'd35,
		OP_TSX   = 6'd36,
		OP_TXA   = 6'd37,
		OP_TXS   = 6'd38,
		OP_TYA   = 6'd39,
		OP_SEC   = 6'd40,
		OP_SED   = 6'd41,
		OP_SEI   = 6'd42,
		OP_CLC   = 6'd43,
		OP_CLD   = 6'd44,
		OP_CLI   = 6'd45,
		OP_CLV   = 6'd46,
		OP_LSR_A = 6'd47,
		OP_ASL_A = 6'd48,
		OP_ROL_A = 6'd49,
		OP_ROR_A = 6'd50,
		OP_PLP   = 6'd51
	} op_t;

	typedef struct packed {
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] xr;
		logic [DATA_W-1:0] yr;
		logic [DATA_W-1:0] sp;
		logic [FLAG_W-1:0] flags;
	} arch_state_t;

	// status byte: N V 1 B=0 D I Z C
	function automatic logic [DATA_W-1:0] pack_status(input logic [FLAG_W-1:0] f);
		return {f[FLG_N], f[FLG_V], 1'b1, 1'b0, f[FLG_D], f[FLG_I], f[FLG_Z], f[FLG_C]};
	endfunction

endpackage

`default_nettype wire

>>> sv/cae_ifs.sv
// valid/ready channel interfaces for the execute core
// depends on cae_pkg for field widths
`default_nettype none

interface cae_in_if;
	logic                       valid;
	logic                       ready;
	logic [cae_pkg::OP_W-1:0]   op;
	logic [cae_pkg::DATA_W-1:0] operand;

	modport source (output valid, op, operand, input ready);
	modport sink   (input valid, op, operand, output ready);
endinterface

interface cae_out_if;
	logic                       valid;
	logic                       ready;
	logic [cae_pkg::DATA_W-1:0] write_value;
	logic [cae_pkg::DATA_W-1:0] acc_out;
	logic [cae_pkg::DATA_W-1:0] xreg_out;
	logic [cae_pkg::DATA_W-1:0] yreg_out;
	logic [cae_pkg::DATA_W-1:0] sp_out;
	logic [cae_pkg::DATA_W-1:0] status_out;

	modport source (output valid, write_value, acc_out, xreg_out, yreg_out, sp_out,
		status_out, input ready);
	modport sink   (input valid, write_value, acc_out, xreg_out, yreg_out, sp_out,
		status_out, output ready);
endinterface

`default_nettype wire

>>> sv/cae_alu.sv
// combinational execute: next register state and write-back byte for one op
// depends on cae_pkg
`default_nettype none

module cae_alu (
	input  wire logic [cae_pkg::OP_W-1:0]   op,
	input  wire logic [cae_pkg::DATA_W-1:0] operand,
	input  wire cae_pkg::arch_state_t       cur,
	output cae_pkg::arch_state_t            nxt,
	output logic [cae_pkg::DATA_W-1:0]      write_value
);
	import cae_pkg::*;

	function automatic logic [FLAG_W-1:0] set_nz(input logic [FLAG_W-1:0] f,
		input logic [DATA_W-1:0] v);
		logic [FLAG_W-1:0] r;
		r = f;
		r[FLG_Z] = (v == '0);
		r[FLG_N] = v[DATA_W-1];
		return r;
	endfunction

	op_t               op_e;
	logic              c_in;
	logic [DATA_W-1:0] m;
	logic [DATA_W-1:0] m_inc, m_dec;
	logic [DATA_W-1:0] lsr_m, asl_m, rol_m, ror_m;
	logic [DATA_W-1:0] add_b;
	logic              add_cin;
	logic [DATA_W:0]   sum9;
	logic              add_v;
	logic [DATA_W-1:0] cmp_r, cmp_m;
	logic [DATA_W:0]   diff9;
	logic [DATA_W-1:0] tmp;

	assign op_e  = op_t'(op);
	assign m     = operand;
	assign c_in  = cur.flags[FLG_C];
	assign m_inc = m + 8'd1;
	assign m_dec = m - 8'd1;
	assign lsr_m = {1'b0, m[DATA_W-1:1]};
	assign ror_m = {c_in, m[DATA_W-1:1]};
	assign asl_m = {m[DATA_W-2:0], 1'b0};
	assign rol_m = {m[DATA_W-2:0], c_in};

	// shared adder for adc, sbc, isb and rra
	always_comb begin
		case (op_e)
			OP_SBC:  add_b = ~m;
			OP_ISB:  add_b = ~m_inc;
			OP_RRA:  add_b = ror_m;
			default: add_b = m;
		endcase
	end
	// rra rotates first, so its add sees the bit shifted out as carry
	assign add_cin = (op_e == OP_RRA) ? m[0] : c_in;
	assign sum9    = {1'b0, cur.acc} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
	assign add_v   = (cur.acc[DATA_W-1] == add_b[DATA_W-1]) &&
		(sum9[DATA_W-1] != cur.acc[DATA_W-1]);

	// shared comparator, carry out means r >= m
	always_comb begin
		case (op_e)
			OP_CPX:  cmp_r = cur.xr;
			OP_CPY:  cmp_r = cur.yr;
			default: cmp_r = cur.acc;
		endcase
	end
	assign cmp_m = (op_e == OP_DCP) ? m_dec : m;
	assign diff9 = {1'b0, cmp_r} + {1'b0, ~cmp_m} + {{DATA_W{1'b0}}, 1'b1};

	always_comb begin
		nxt         = cur;
		write_value = m;
		tmp         = '0;
		unique case (op_e)
			OP_ADC, OP_SBC, OP_ISB, OP_RRA: begin
				if (op_e == OP_ISB) write_value = m_inc;
				if (op_e == OP_RRA) write_value = ror_m;
				nxt.acc          = sum9[DATA_W-1:0];
				nxt.flags        = set_nz(cur.flags, sum9[DATA_W-1:0]);
				nxt.flags[FLG_C] = sum9[DATA_W];
				nxt.flags[FLG_V] = add_v;
			end
			OP_CMP, OP_CPX, OP_CPY, OP_DCP: begin
				if (op_e == OP_DCP) write_value = m_dec;
				nxt.flags        = set_nz(cur.flags, diff9[DATA_W-1:0]);
				nxt.flags[FLG_C] = diff9[DATA_W];
			end
			OP_DEC: begin
				write_value = m_dec;
				nxt.flags   = set_nz(cur.flags, m_dec);
			end
			OP_INC: begin
				write_value = m_inc;
				nxt.flags   = set_nz(cur.flags, m_inc);
			end
			OP_LSR, OP_ROR: begin
				write_value      = (op_e == OP_ROR) ? ror_m : lsr_m;
				nxt.flags        = set_nz(cur.flags, write_value);
				nxt.flags[FLG_C] = m[0];
			end
			OP_ASL, OP_ROL: begin
				write_value      = (op_e == OP_ROL) ? rol_m : asl_m;
				nxt.flags        = set_nz(cur.flags, write_value);
				nxt.flags[FLG_C] = m[DATA_W-1];
			end
			OP_BIT: begin
				nxt.flags[FLG_V] = m[6];
				nxt.flags[FLG_N] = m[7];
				nxt.flags[FLG_Z] = ((m & cur.acc) == '0);
			end
			OP_AND, OP_EOR, OP_ORA: begin
				if (op_e == OP_AND)      tmp = cur.acc & m;
				else if (op_e == OP_EOR) tmp = cur.acc ^ m;
				else                     tmp = cur.acc | m;
				nxt.acc   = tmp;
				nxt.flags = set_nz(cur.flags, tmp);
			end
			OP_LDA: begin
				nxt.acc   = m;
				nxt.flags = set_nz(cur.flags, m);
			end
			OP_LDX: begin
				nxt.xr    = m;
				nxt.flags = set_nz(cur.flags, m);
			end
			OP_LDY: begin
				nxt.yr    = m;
				nxt.flags = set_nz(cur.flags, m);
			end
			OP_STA: write_value = cur.acc;
			OP_STX: write_value = cur.xr;
			OP_STY: write_value = cur.yr;
			OP_NOP: ;
			OP_LAX: begin
				nxt.acc   = m;
				nxt.xr    = m;
				nxt.flags = set_nz(cur.flags, m);
			end
			OP_SAX: write_value = cur.acc & cur.xr;
			OP_SLO, OP_RLA: begin
				write_value      = (op_e == OP_RLA) ? rol_m : asl_m;
				tmp              = (op_e == OP_RLA) ? (cur.acc & rol_m) : (cur.acc | asl_m);
				nxt.acc          = tmp;
				nxt.flags        = set_nz(cur.flags, tmp);
				nxt.flags[FLG_C] = m[DATA_W-1];
			end
			OP_SRE: begin
				write_value      = lsr_m;
				tmp              = cur.acc ^ lsr_m;
				nxt.acc          = tmp;
				nxt.flags        = set_nz(cur.flags, tmp);
				nxt.flags[FLG_C] = m[0];
			end
			OP_INX, OP_DEX: begin
				tmp       = (op_e == OP_INX) ? (cur.xr + 8'd1) : (cur.xr - 8'd1);
				nxt.xr    = tmp;
				nxt.flags = set_nz(cur.flags, tmp);
			end
			OP_INY, OP_DEY: begin
				tmp       = (op_e == OP_INY) ? (cur.yr + 8'd1) : (cur.yr - 8'd1);
				nxt.yr    = tmp;
				nxt.flags = set_nz(cur.flags, tmp);
			end
			OP_TAX: begin
				nxt.xr    = cur.acc;
				nxt.flags = set_nz(cur.flags, cur.acc);
			end
			OP_TAY: begin
				nxt.yr    = cur.acc;
				nxt.flags = set_nz(cur.flags, cur.acc);
			end
			OP_TSX: begin
				nxt.xr    = cur.sp;
				nxt.flags = set_nz(cur.flags, cur.sp);
			end
			OP_TXA: begin
				nxt.acc   = cur.xr;
				nxt.flags = set_nz(cur.flags, cur.xr);
			end
			OP_TXS: nxt.sp = cur.xr;
			OP_TYA: begin
				nxt.acc   = cur.yr;
				nxt.flags = set_nz(cur.flags, cur.yr);
			end
			OP_SEC: nxt.flags[FLG_C] = 1'b1;
			OP_SED: nxt.flags[FLG_D] = 1'b1;
			OP_SEI: nxt.flags[FLG_I] = 1'b1;
			OP_CLC: nxt.flags[FLG_C] = 1'b0;
			OP_CLD: nxt.flags[FLG_D] = 1'b0;
			OP_CLI: nxt.flags[FLG_I] = 1'b0;
			OP_CLV: nxt.flags[FLG_V] = 1'b0;
			OP_LSR_A, OP_ROR_A: begin
				tmp = {(op_e == OP_ROR_A) ? c_in : 1'b0, cur.acc[DATA_W-1:1]};
				nxt.acc          = tmp;
				nxt.flags        = set_nz(cur.flags, tmp);
				nxt.flags[FLG_C] = cur.acc[0];
			end
			OP_ASL_A, OP_ROL_A: begin
				tmp = {cur.acc[DATA_W-2:0], (op_e == OP_ROL_A) ? c_in : 1'b0};
				nxt.acc          = tmp;
				nxt.flags        = set_nz(cur.flags, tmp);
				nxt.flags[FLG_C] = cur.acc[DATA_W-1];
			end
			// operand bits 4 and 5 are dropped
			OP_PLP: nxt.flags = {m[7], m[6], m[3], m[2], m[1], m[0]};
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/cpu_alu_register_execute_top.sv
// top level of the 8-bit cpu execute core: input stage, register state, result stage
// depends on cae_pkg, cae_ifs (cae_in_if, cae_out_if) and cae_alu
//
// usage:
//  - in_ch carries one beat per instruction: op (6-bit code) and operand (the
//    memory/immediate byte, or the flags byte for the flag load op)
//  - out_ch returns one beat per input beat, in order: the byte to write back,
//    then a, x, y, sp and the packed status byte N V 1 0 D I Z C
//  - path: a taken beat sits in the input stage, runs through the alu from there,
//    and is registered into the result stage that drives out_ch once it is free
//  - throughput: one beat per cycle while out_ch.ready is high; the 8-bit adder,
//    comparator and flag logic between the input and result stages set the cycle
//  - the next instruction sees register state written by the one before it,
//    since the register file updates at the same edge the result is captured
//  - reset (arst_n low) clears a, x, y, sp and all flags and empties both stages
//  - when out_ch.ready is low the result stage holds, the input stage fills,
//    and in_ch.ready drops until the receiver takes the waiting beat
//  - unused op codes leave all registers alone and return the operand as is
`default_nettype none

module cpu_alu_register_execute_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cae_in_if.sink     in_ch,
	cae_out_if.source  out_ch
);
	import cae_pkg::*;

	// input stage
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [DATA_W-1:0] operand_s1;

	// architectural registers
	arch_state_t       state_q;
	arch_state_t       state_nxt;
	logic [DATA_W-1:0] wval_nxt;

	// result stage
	logic              valid_s2;
	logic [DATA_W-1:0] wval_s2;
	arch_state_t       state_s2;

	logic              adv_s1;
	logic              take_in;

	// execute whenever the result stage is free or being drained this cycle
	assign adv_s1  = valid_s1 && (!valid_s2 || out_ch.ready);
	assign take_in = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1      <= in_ch.op;
			operand_s1 <= in_ch.operand;
		end
	end

	cae_alu u_alu (
		.op          (op_s1),
		.operand     (operand_s1),
		.cur         (state_q),
		.nxt         (state_nxt),
		.write_value (wval_nxt)
	);

	// register file commits together with the result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			wval_s2  <= wval_nxt;
			state_s2 <= state_nxt;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.write_value = wval_s2;
	assign out_ch.acc_out     = state_s2.acc;
	assign out_ch.xreg_out    = state_s2.xr;
	assign out_ch.yreg_out    = state_s2.yr;
	assign out_ch.sp_out      = state_s2.sp;
	assign out_ch.status_out  = pack_status(state_s2.flags);

	// register state only moves when an instruction executes
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("register state changed without an executed beat");

	// an executed beat always lands in the result stage
	a_exec_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("executed beat missing from result stage");

	// both stages full and receiver stalled: no new beat may be taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken while pipeline is blocked");

	// fixed status bits
	a_status_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (out_ch.status_out[5] && !out_ch.status_out[4]))
		else $error("status byte fixed bits wrong");

endmodule

`default_nettype wire
